// File: rtl/wad_pkg.sv
// Shared types and constants for the windowed average / deviation block.
// Used by wad_ctrl, wad_datapath and the top level; depends on nothing.
package wad_pkg;

	localparam int TIME_BITS = 32;
	localparam logic [TIME_BITS-1:0] SPAN_RESET = 32'd1000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_RESULT
	} wad_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // latch the input beat
		logic update;    // fold the held sample into the window
		logic div_load;  // start the mean division
		logic div_step;  // one restoring division step
		logic finish;    // load result register, restart window
	} wad_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic close;     // window closes with the held sample
		logic div_done;  // all quotient bits produced
		logic out_free;  // result register can take a new beat
	} wad_sts_t;

endpackage

// File: rtl/wad_ctrl.sv
// Controller state machine for the windowed average / deviation block.
// Depends on wad_pkg for the state enum and the command/status structs.
module wad_ctrl
	import wad_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  wad_sts_t sts,
	output wad_cmd_t cmd
);

	wad_state_t state_q;
	wad_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = sts.close ? ST_DIVIDE : ST_IDLE;
			end
			ST_DIVIDE: begin
				if (sts.div_done) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_UPDATE: begin
				cmd.update   = 1'b1;
				cmd.div_load = sts.close;
			end
			ST_DIVIDE: begin
				cmd.div_step = !sts.div_done;
			end
			ST_RESULT: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/wad_datapath.sv
// Datapath: window accumulators, restoring divider, deviation and result register.
// Depends on wad_pkg; driven by wad_ctrl through wad_cmd_t.
module wad_datapath
	import wad_pkg::*;
#(
	parameter int SAMPLE_BITS = 10,
	parameter int COUNT_BITS  = 16,
	localparam int IN_W  = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * SAMPLE_BITS - 1 + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IN_W-1:0]      s_tdata,
	input  logic                 cfg_valid,
	input  logic [TIME_BITS-1:0] cfg_data,
	input  wad_cmd_t             cmd,
	output wad_sts_t             sts,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata
);

	localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
	localparam int STEP_BITS = $clog2(SUM_BITS + 1);

	logic [TIME_BITS-1:0]   span_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [TIME_BITS-1:0]   start_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [COUNT_BITS:0]    rem_q;
	logic [SUM_BITS-1:0]    quo_q;
	logic [STEP_BITS-1:0]   step_q;
	logic                   m_tvalid_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [SAMPLE_BITS-2:0] dev_q;

	logic [SUM_BITS-1:0]    sum_next;
	logic [TIME_BITS-1:0]   elapsed;
	logic [COUNT_BITS:0]    trial;
	logic [COUNT_BITS:0]    divisor;
	logic                   trial_ge;
	logic [SAMPLE_BITS-1:0] mean;
	logic [SAMPLE_BITS-1:0] up;
	logic [SAMPLE_BITS-1:0] down;
	logic [SAMPLE_BITS-1:0] larger;

	assign sum_next = sum_q + SUM_BITS'(sample_q);
	assign elapsed  = now_q - start_q;

	assign sts.close    = (elapsed >= span_q) ||
	                      (count_q == {{(COUNT_BITS-1){1'b1}}, 1'b0});
	assign sts.div_done = (step_q == '0);
	assign sts.out_free = !m_tvalid_q || m_tready;

	// restoring step: shift in the next dividend bit, subtract if it fits
	assign divisor  = {1'b0, count_q};
	assign trial    = {rem_q[COUNT_BITS-1:0], quo_q[SUM_BITS-1]};
	assign trial_ge = (trial >= divisor);

	// quotient never exceeds the window maximum, so the low bits hold it
	assign mean   = quo_q[SAMPLE_BITS-1:0];
	assign up     = (max_q >= mean) ? max_q - mean : '0;
	assign down   = (mean >= min_q) ? mean - min_q : '0;
	assign larger = (up > down) ? up : down;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= SPAN_RESET;
		end else if (cfg_valid) begin
			span_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= s_tdata[SAMPLE_BITS-1:0];
			now_q    <= s_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			sum_q   <= '0;
			count_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
		end else if (cmd.update) begin
			sum_q   <= sum_next;
			count_q <= count_q + 1'b1;
			if (sample_q < min_q) min_q <= sample_q;
			if (sample_q > max_q) max_q <= sample_q;
		end else if (cmd.finish) begin
			start_q <= now_q;
			sum_q   <= '0;
			count_q <= '0;
			min_q   <= '1;
			max_q   <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_load) begin
			step_q <= STEP_BITS'(SUM_BITS);
		end else if (cmd.div_step) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= sum_next;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial - divisor : trial;
			quo_q <= {quo_q[SUM_BITS-2:0], trial_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			mean_q <= mean;
			dev_q  <= larger[SAMPLE_BITS-1:1];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({dev_q, mean_q});

endmodule

// File: rtl/windowed_average_deviation_core.sv
// Top level of the windowed average / deviation block.
// Depends on wad_pkg, wad_ctrl and wad_datapath.
//
// Usage:
//   s_* channel: one beat per sample; s_tdata = {now_ms, sample}, sample in the
//   lowest SAMPLE_BITS bits, the 32-bit millisecond timestamp above it.
//   cfg_* channel: write of window_span_ms (32 bits), always ready; write it
//   only while the block is idle.
//   m_* channel: one beat per closed window; m_tdata = {deviation, mean}.
// Sequence:
//   A sample that leaves the window open is accepted and then folded in.
//   A sample that closes the window is accepted and folded in, then a restoring
//   divider produces one quotient bit per cycle; the controller sees it finish,
//   and a final step forms the deviation and loads the result register.
//   s_tready is high only between samples.
// Reset:
//   arst_n clears the window (start 0, empty sum and count), sets the span
//   to 1000 ms and drops m_tvalid.
// Back-pressure:
//   A result waits in the output register while m_tready is low; further
//   samples are still taken, and only a second closing window stalls in its
//   final cycle until the pending beat has been taken.
module windowed_average_deviation_core
	import wad_pkg::*;
#(
	parameter int SAMPLE_BITS = 10,
	parameter int COUNT_BITS  = 16,
	localparam int IN_W  = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * SAMPLE_BITS - 1 + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // sample, now_ms (lowest first)
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // mean, deviation (lowest first)
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TIME_BITS-1:0] cfg_data   // window_span_ms
);

	wad_cmd_t cmd;
	wad_sts_t sts;

	// span register takes every write beat at once
	assign cfg_ready = 1'b1;

	wad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wad_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
